>>> rtl/b64e_pkg.sv
package b64e_pkg;

	localparam int TERM_MAX_BYTES_DEF = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef enum logic [1:0] {
		REG_MAX_LINE   = 2'd0,
		REG_TERM_BYTES = 2'd1,
		REG_TERM_LEN   = 2'd2
	} cfg_reg_t;

	// One queued job: optional terminator, optional group, optional closing terminator.
	typedef struct packed {
		logic        pre;
		logic        grp;
		logic        post;
		logic [1:0]  pads;
		logic [23:0] bytes;
	} job_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return w + 8'd65;
		end else if (v < 6'd52) begin
			return w + 8'd71;
		end else if (v < 6'd62) begin
			return w - 8'd4;
		end else if (v == 6'd62) begin
			return 8'h2B;
		end else begin
			return 8'h2F;
		end
	endfunction

	function automatic logic [7:0] term_byte(input logic [31:0] t, input logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		if (!i[2]) begin
			r = t[{i[1:0], 3'b000} +: 8];
		end
		return r;
	endfunction

endpackage

>>> rtl/b64e_front.sv
module b64e_front import b64e_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        flush,
	input  logic [9:0]  max_line_length,
	input  logic        tlen_nz,
	input  logic        q_full,
	output logic        push,
	output job_t        push_job
);

	logic [1:0]  gc_q;
	logic [10:0] lc_q;
	logic [7:0]  grp_q [3];

	logic [1:0]  gc_n;
	logic [1:0]  gc_next;
	logic [10:0] lc_n;
	logic [7:0]  b [3];
	logic        wrap;
	logic        line_full;
	logic        accept;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign wrap      = max_line_length != 10'd0;
	assign line_full = wrap && (lc_q >= {1'b0, max_line_length});

	always_comb begin
		gc_n = gc_q + {1'b0, has_byte};
		b = grp_q;
		if (has_byte) begin
			b[gc_q] = data_byte;
		end
		push_job = '0;
		gc_next = gc_n;
		lc_n = lc_q;
		if (gc_n == 2'd3) begin
			push_job.grp   = 1'b1;
			push_job.pre   = line_full && tlen_nz;
			push_job.bytes = {b[2], b[1], b[0]};
			gc_next = 2'd0;
			if (line_full) begin
				lc_n = 11'd0;
			end
			if (wrap) begin
				lc_n = lc_n + 11'd4;
			end
		end else if (flush && gc_n != 2'd0) begin
			push_job.grp   = 1'b1;
			push_job.pre   = line_full && tlen_nz;
			push_job.pads  = 2'd3 - gc_n;
			push_job.bytes = {8'h00, (gc_n == 2'd2) ? b[1] : 8'h00, b[0]};
			gc_next = 2'd0;
		end
		if (flush) begin
			push_job.post = wrap && tlen_nz;
			lc_n = 11'd0;
		end
		push = accept && (push_job.grp || push_job.post);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gc_q <= 2'd0;
			lc_q <= 11'd0;
		end else if (accept) begin
			gc_q <= gc_next;
			lc_q <= lc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has_byte) begin
			grp_q[gc_q] <= data_byte;
		end
	end

	a_gc_range: assert property (@(posedge clk) disable iff (!arst_n) gc_q != 2'd3)
		else $error("Group count reached three between requests.");
	a_pre_grp: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_job.grp || !push_job.pre))
		else $error("Leading terminator queued without a group.");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_full)
		else $error("Job pushed into a full queue.");

endmodule

>>> rtl/b64e_fifo.sv
module b64e_fifo import b64e_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	output logic q_valid,
	input  logic pop,
	output job_t q_job
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t          mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;

	assign full    = count_q == CW'(QUEUE_DEPTH);
	assign q_valid = count_q != '0;
	assign q_job   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("Queue count exceeds its depth.");
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_valid)
		else $error("Pop from an empty queue.");
	a_ptr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && !full) |=> count_q == $past(count_q) + 1'b1)
		else $error("Queue count did not follow a push.");

endmodule

>>> rtl/b64e_back.sv
module b64e_back import b64e_pkg::*; #(
	parameter int TERM_MAX_BYTES = TERM_MAX_BYTES_DEF,
	parameter int LEN_W = $clog2(TERM_MAX_BYTES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  job_t             q_job,
	output logic             pop,
	input  logic [31:0]      terminator_bytes,
	input  logic [LEN_W-1:0] tlen,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       out_char,
	output logic             last
);

	localparam int CNT_W = (LEN_W > 2) ? LEN_W : 2;

	typedef enum logic [2:0] {
		PH_PRE  = 3'b001,
		PH_GRP  = 3'b010,
		PH_POST = 3'b100
	} phase_t;

	logic             busy_q;
	job_t             job_q;
	phase_t           phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic             m_tvalid_q;
	logic [7:0]       m_tdata_q;
	logic             m_tlast_q;

	logic             advance;
	logic             phase_end;
	logic             job_done;
	phase_t           phase_next;
	logic [7:0]       ch;
	logic [5:0]       sextet;
	logic [7:0]       b0, b1, b2;
	phase_t           first_phase;

	assign advance = busy_q && (!m_tvalid_q || m_tready);
	assign {b2, b1, b0} = job_q.bytes;
	assign first_phase = q_job.pre ? PH_PRE : (q_job.grp ? PH_GRP : PH_POST);

	always_comb begin
		phase_end  = 1'b0;
		job_done   = 1'b0;
		phase_next = phase_q;
		ch         = 8'h00;
		unique case (cnt_q[1:0])
			2'd0: sextet = b0[7:2];
			2'd1: sextet = {b0[1:0], b1[7:4]};
			2'd2: sextet = {b1[3:0], b2[7:6]};
			default: sextet = b2[5:0];
		endcase
		unique case (phase_q)
			PH_PRE: begin
				ch = term_byte(terminator_bytes, 3'(cnt_q));
				phase_end = (cnt_q + 1'b1) == CNT_W'(tlen);
				phase_next = PH_GRP;
			end
			PH_GRP: begin
				ch = b64_char(sextet);
				if ((3'(cnt_q[1:0]) + 3'(job_q.pads)) >= 3'd4) begin
					ch = PAD_CHAR;
				end
				phase_end = cnt_q[1:0] == 2'd3;
				phase_next = PH_POST;
				job_done = !job_q.post;
			end
			PH_POST: begin
				ch = term_byte(terminator_bytes, 3'(cnt_q));
				phase_end = (cnt_q + 1'b1) == CNT_W'(tlen);
				job_done = 1'b1;
			end
			default: begin
				phase_end = 1'b1;
				job_done = 1'b1;
			end
		endcase
		job_done = job_done && phase_end;
	end

	assign pop = q_valid && (!busy_q || (advance && job_done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			phase_q    <= PH_PRE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q  <= 1'b1;
				phase_q <= first_phase;
				cnt_q   <= '0;
			end else if (advance) begin
				if (job_done) begin
					busy_q <= 1'b0;
				end else if (phase_end) begin
					phase_q <= phase_next;
					cnt_q   <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (advance) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		if (advance) begin
			m_tdata_q <= ch;
			m_tlast_q <= job_done;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign out_char = m_tdata_q;
	assign last     = m_tlast_q;

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(phase_q))
		else $error("Phase register is not one-hot.");
	a_pre_has_grp: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && phase_q == PH_PRE) |-> job_q.grp)
		else $error("Leading terminator without a following group.");
	a_grp_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && phase_q == PH_GRP) |-> cnt_q < CNT_W'(4))
		else $error("Group character index out of range.");
	a_term_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (phase_q == PH_PRE || phase_q == PH_POST)) |-> cnt_q < CNT_W'(tlen))
		else $error("Terminator byte index out of range.");

endmodule

>>> rtl/base64_stream_encoder_line_wrap.sv
// An accepted item passes the job queue and the back end job register before its first
// character is registered in the output stage. Throughput: one output character per cycle
// while m_tready is high; an item is accepted every cycle while the four-entry job queue has
// room, so the output port (up to 2*TERM_MAX_BYTES+4 characters per item) sets the sustained rate.
// Reset: arst_n clears the group and line counts, the queue and the output stage at once,
// and loads the register defaults (no wrapping, CR LF terminator of two bytes).
module base64_stream_encoder_line_wrap import b64e_pkg::*; #(
	parameter int TERM_MAX_BYTES = TERM_MAX_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte
	input  logic        s_tuser,  // has_byte
	input  logic        s_tlast,  // flush
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // out_char
	output logic        m_tlast   // last
);

	localparam int LEN_W = $clog2(TERM_MAX_BYTES + 1);

	logic [9:0]       max_line_q;
	logic [31:0]      term_bytes_q;
	logic [2:0]       term_len_q;
	logic [LEN_W-1:0] tlen_eff;

	logic q_full;
	logic push;
	job_t push_job;
	logic q_valid;
	logic pop;
	job_t q_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_line_q   <= 10'd0;
			term_bytes_q <= 32'h0000_0A0D;
			term_len_q   <= 3'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_LINE:   max_line_q   <= cfg_data[9:0];
				REG_TERM_BYTES: term_bytes_q <= cfg_data;
				REG_TERM_LEN:   term_len_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign tlen_eff = (int'(term_len_q) > TERM_MAX_BYTES) ? LEN_W'(TERM_MAX_BYTES)
	                                                      : LEN_W'(term_len_q);

	b64e_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.data_byte       (s_tdata),
		.has_byte        (s_tuser),
		.flush           (s_tlast),
		.max_line_length (max_line_q),
		.tlen_nz         (tlen_eff != '0),
		.q_full          (q_full),
		.push            (push),
		.push_job        (push_job)
	);

	b64e_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.q_valid  (q_valid),
		.pop      (pop),
		.q_job    (q_job)
	);

	b64e_back #(
		.TERM_MAX_BYTES (TERM_MAX_BYTES),
		.LEN_W          (LEN_W)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_job            (q_job),
		.pop              (pop),
		.terminator_bytes (term_bytes_q),
		.tlen             (tlen_eff),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.out_char         (m_tdata),
		.last             (m_tlast)
	);

endmodule

>>> tb/base64_stream_encoder_line_wrap_checker.sv
`timescale 1ns / 1ps
module base64_stream_encoder_line_wrap_checker import b64e_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte
	input  logic        s_tuser,  // has_byte
	input  logic        s_tlast,  // flush
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,  // out_char
	input  logic        m_tlast,  // last
	output int          mismatches,
	output int          chars_owed
);

	localparam int REPORT_CAP = 100;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} enc_char_t;

	enc_char_t   char_fifo[$];
	enc_char_t   request_chars[$];
	enc_char_t   want;
	string       alphabet_str;
	logic [9:0]  line_max;
	logic [31:0] term_word;
	logic [2:0]  term_len;
	logic [7:0]  grp[3];
	logic [1:0]  grp_fill;
	logic [10:0] line_used;

	initial alphabet_str = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	task automatic stage_char(logic [7:0] c);
		enc_char_t e;
		e.ch = c;
		e.last = 1'b0;
		request_chars.push_back(e);
	endtask

	task automatic stage_term();
		int n;
		n = (int'(term_len) > TERM_MAX_BYTES_DEF) ? TERM_MAX_BYTES_DEF : int'(term_len);
		for (int i = 0; i < n; i++) begin
			stage_char((i < 4) ? term_word[8*i +: 8] : 8'h00);
		end
	endtask

	task automatic stage_group(int pads);
		logic [23:0] w;
		w = {grp[0], grp[1], grp[2]};
		for (int i = 0; i < 4; i++) begin
			if (i >= 4 - pads) begin
				stage_char(PAD_CHAR);
			end else begin
				stage_char(alphabet_str.getc(int'(w[18 - 6*i +: 6])));
			end
		end
	endtask

	// Works out every character that one accepted request produces.
	task automatic encode_request(logic [7:0] d, logic has, logic fl);
		logic      wrap;
		enc_char_t tail;
		wrap = (line_max != 10'd0);
		request_chars.delete();
		if (has && grp_fill < 2'd3) begin
			grp[grp_fill] = d;
			grp_fill = grp_fill + 2'd1;
		end
		if (grp_fill == 2'd3) begin
			if (wrap && line_used >= {1'b0, line_max}) begin
				stage_term();
				line_used = 11'd0;
			end
			stage_group(0);
			grp_fill = 2'd0;
			if (wrap) begin
				line_used = line_used + 11'd4;
			end
		end else if (fl && grp_fill != 2'd0) begin
			if (wrap && line_used >= {1'b0, line_max}) begin
				stage_term();
			end
			line_used = 11'd0;
			for (int i = grp_fill; i < 3; i++) begin
				grp[i] = 8'h00;
			end
			stage_group(3 - int'(grp_fill));
			grp_fill = 2'd0;
		end
		if (fl) begin
			if (wrap) begin
				stage_term();
			end
			line_used = 11'd0;
		end
		if (request_chars.size() > 0) begin
			tail = request_chars.pop_back();
			tail.last = 1'b1;
			request_chars.push_back(tail);
		end
		foreach (request_chars[i]) begin
			char_fifo.push_back(request_chars[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_max = 10'd0;
			term_word = 32'h0000_0A0D;
			term_len = 3'd2;
			grp[0] = 8'h00;
			grp[1] = 8'h00;
			grp[2] = 8'h00;
			grp_fill = 2'd0;
			line_used = 11'd0;
			char_fifo.delete();
			mismatches = 0;
			chars_owed = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_LINE:   line_max = cfg_data[9:0];
					REG_TERM_BYTES: term_word = cfg_data;
					REG_TERM_LEN:   term_len = cfg_data[2:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (char_fifo.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_CAP) begin
						$display("%0t: out_char expected none, got %h (last %b)", $time,
							m_tdata, m_tlast);
					end
				end else begin
					want = char_fifo.pop_front();
					if (m_tdata !== want.ch) begin
						mismatches++;
						if (mismatches <= REPORT_CAP) begin
							$display("%0t: out_char expected %h, got %h", $time, want.ch,
								m_tdata);
						end
					end
					if (m_tlast !== want.last) begin
						mismatches++;
						if (mismatches <= REPORT_CAP) begin
							$display("%0t: last expected %b, got %b", $time, want.last,
								m_tlast);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				encode_request(s_tdata, s_tuser, s_tlast);
			end
			chars_owed = char_fifo.size();
		end
	end

endmodule

>>> tb/base64_stream_encoder_line_wrap_test.sv
`timescale 1ns / 1ps
module base64_stream_encoder_line_wrap_test;
	import b64e_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_REQUESTS = 41;
	localparam int PHASES = 8;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	int          mismatches;
	int          chars_owed;
	int          cycles = 0;
	int          stall_left = 0;
	logic        calm = 1'b0;

	base64_stream_encoder_line_wrap i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	base64_stream_encoder_line_wrap_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.chars_owed (chars_owed)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("base64_stream_encoder_line_wrap_test NOT OK");
			$finish;
		end
	end

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0) begin
					stall_left = gap_len();
				end
			end
		end
	end

	task automatic send_request(logic [7:0] d, logic has, logic fl);
		int gap;
		gap = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= has;
		s_tlast <= fl;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (chars_owed != 0);
	endtask

	// A request that creates no character may still be in flight, so settle before writes.
	task automatic wait_idle();
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_config(logic [9:0] ml, logic [31:0] tw, logic [2:0] tl);
		cfg_we <= 1'b1;
		cfg_index <= REG_MAX_LINE;
		cfg_data <= {22'd0, ml};
		@(negedge clk);
		cfg_index <= REG_TERM_BYTES;
		cfg_data <= tw;
		@(negedge clk);
		cfg_index <= REG_TERM_LEN;
		cfg_data <= {29'd0, tl};
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_request(output logic counted);
		int   r;
		logic has;
		logic fl;
		r = $urandom_range(0, 99);
		has = (r >= 10);
		fl = (r < 6) || (r >= 10 && r < 18);
		counted = has || fl;
		send_request(8'($urandom_range(0, 255)), has, fl);
	endtask

	initial begin
		int   useful;
		logic counted;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MAX_LINE;
		cfg_data = 32'd0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: no wrapping.
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'hFF, 1'b1, 1'b0);
		send_request(8'h80, 1'b1, 1'b0);
		send_request(8'hAA, 1'b0, 1'b0);
		send_request(8'hFF, 1'b1, 1'b0);
		send_request(8'hFF, 1'b1, 1'b0);
		send_request(8'hFF, 1'b1, 1'b1);
		send_request(8'h01, 1'b1, 1'b1);
		send_request(8'h7E, 1'b1, 1'b0);
		send_request(8'h3C, 1'b1, 1'b1);
		send_request(8'h00, 1'b0, 1'b1);

		// Short lines: the full line, flush after a full line and an empty flush.
		wait_idle();
		set_config(10'd4, 32'hDEAD_BEEF, 3'd4);
		send_request(8'h12, 1'b1, 1'b0);
		send_request(8'h34, 1'b1, 1'b0);
		send_request(8'h56, 1'b1, 1'b0);
		send_request(8'h9A, 1'b1, 1'b0);
		send_request(8'hBC, 1'b1, 1'b0);
		send_request(8'hDE, 1'b1, 1'b1);
		send_request(8'h00, 1'b0, 1'b1);
		send_request(8'h11, 1'b1, 1'b0);
		send_request(8'h22, 1'b1, 1'b0);
		send_request(8'h33, 1'b1, 1'b0);
		send_request(8'h44, 1'b1, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p)
				0: set_config(10'd0, $urandom, 3'($urandom_range(0, 7)));
				1: set_config(10'd1, 32'hFFFF_FFFF, 3'd4);
				2: set_config(10'd1023, 32'h0000_0000, 3'd7);
				3: set_config(10'($urandom_range(1, 12)), $urandom, 3'd0);
				default: set_config(10'($urandom_range(1, 24)), $urandom,
					3'($urandom_range(1, 7)));
			endcase
			calm = (p == 3);
			useful = 0;
			while (useful < PHASE_REQUESTS) begin
				random_request(counted);
				if (counted) begin
					useful++;
					if (p == 4 && useful == PHASE_REQUESTS / 2) begin
						drain();
					end
				end
			end
		end
		calm = 1'b0;

		wait_idle();
		if (mismatches == 0) begin
			$display("base64_stream_encoder_line_wrap_test OK");
		end else begin
			$display("base64_stream_encoder_line_wrap_test NOT OK");
		end
		$finish;
	end

endmodule
